@@ sv/segment_table_point_query_macros.svh @@
// assertion macros for the segment table checker
`ifndef SEGMENT_TABLE_POINT_QUERY_MACROS_SVH
`define SEGMENT_TABLE_POINT_QUERY_MACROS_SVH
`define STPQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define STPQ_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

@@ sv/stpq_pkg.sv @@
// shared types and codes for the segment table
package stpq_pkg;
  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_CONTAINS = 3'd2,
    OP_POINT    = 3'd3,
    OP_REGION   = 3'd4
  } op_t;
  // selector codes with no operation behind them
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int IN_BITS  = 168;
  localparam int OUT_BITS = 24;
  localparam int MASK_BITS = 16;
  localparam int CNT_BITS = 5;
  typedef struct packed {
    logic hit;
    logic eq;
  } eval_t;
endpackage

@@ sv/stpq_eval.sv @@
// shared per-entry evaluation unit: equality, point-on-segment, region test
module stpq_eval #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic [2:0]                    op,
  input  logic signed [COORD_BITS-1:0]  ex0,
  input  logic signed [COORD_BITS-1:0]  ey0,
  input  logic signed [COORD_BITS-1:0]  ex1,
  input  logic signed [COORD_BITS-1:0]  ey1,
  input  logic signed [COORD_BITS-1:0]  sx0,
  input  logic signed [COORD_BITS-1:0]  sy0,
  input  logic signed [COORD_BITS-1:0]  sx1,
  input  logic signed [COORD_BITS-1:0]  sy1,
  input  logic signed [COORD_BITS-1:0]  px,
  input  logic signed [COORD_BITS-1:0]  py,
  input  logic signed [COORD_BITS:0]    rl,
  input  logic signed [COORD_BITS:0]    rb,
  input  logic signed [((COORD_BITS > 16) ? COORD_BITS : 16)+1:0] rxe,
  input  logic signed [((COORD_BITS > 16) ? COORD_BITS : 16)+1:0] rye,
  output stpq_pkg::eval_t               res
);
  import stpq_pkg::*;
  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D + 1;
  // upper bounds add a 16-bit extent to a coordinate
  localparam int E = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
  logic signed [D-1:0] dx, dy, cx, cy;
  logic signed [P-1:0] cross_v, dot_v, len_v;
  logic eq, on_seg, in0, in1;
  logic signed [E-1:0] x0e, y0e, x1e, y1e, rle, rbe;

  assign dx = D'(ex1) - D'(ex0);
  assign dy = D'(ey1) - D'(ey0);
  assign cx = D'(px) - D'(ex0);
  assign cy = D'(py) - D'(ey0);
  assign cross_v = P'(cy) * P'(dx) - P'(cx) * P'(dy);
  assign dot_v = P'(cx) * P'(dx) + P'(cy) * P'(dy);
  assign len_v = P'(dx) * P'(dx) + P'(dy) * P'(dy);
  assign on_seg = (cross_v == '0) && !dot_v[P-1] && (dot_v <= len_v);
  assign eq = (ex0 == sx0) && (ey0 == sy0) && (ex1 == sx1) && (ey1 == sy1);
  assign x0e = E'(ex0);
  assign y0e = E'(ey0);
  assign x1e = E'(ex1);
  assign y1e = E'(ey1);
  assign rle = E'(rl);
  assign rbe = E'(rb);
  assign in0 = (x0e >= rle) && (x0e <= rxe) && (y0e >= rbe) && (y0e <= rye);
  assign in1 = (x1e >= rle) && (x1e <= rxe) && (y1e >= rbe) && (y1e <= rye);

  always_ff @(posedge clk) begin
    res.eq <= eq;
    unique case (op)
      OP_REMOVE, OP_CONTAINS: res.hit <= eq;
      OP_POINT:               res.hit <= on_seg;
      OP_REGION:              res.hit <= in0 || in1;
      default:                res.hit <= 1'b0;
    endcase
  end
endmodule

@@ sv/segment_table_point_query.sv @@
// segment table top level: storage, sequencer and stream ports
// m_tvalid rises after the accepting edge: append and unused ops go from IDLE straight to DONE
// contains, point and region scan each stored entry (SCAN), drain the evaluator (TAIL), then DONE
// remove scans the same way; when entry r is removed, a SHIFT pass moves the later entries down
// one item at a time: the next transfer is accepted only once the result is taken and IDLE is back
// rst clears the entry count and the sequencer; the store itself is not cleared
module segment_table_point_query #(
  parameter int MAX_SEGMENTS = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // op[2:0], seg_x0, seg_y0, seg_x1, seg_y1, query_px, query_py,
  // region_left, region_bottom, region_width, region_height (16 each)
  input  logic [stpq_pkg::IN_BITS-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // match_mask[15:0], match_count[20:16], result_flag[21], status[22]
  output logic [stpq_pkg::OUT_BITS-1:0]  m_tdata
);
  import stpq_pkg::*;
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int C = COORD_BITS;
  localparam int RW = ((C > 16) ? C : 16) + 2;

  typedef enum logic [2:0] {IDLE, SCAN, TAIL, SHIFT, DONE} state_t;
  state_t state;

  logic [4*C-1:0] mem [MAX_SEGMENTS];
  logic [4*C-1:0] rd;
  logic [4*C-1:0] in_seg;
  logic [CW-1:0]  count;
  logic [CW-1:0]  idx, hidx, hidx1, ridx;
  logic           hv, hv1;
  logic [2:0]     op;
  logic [4*C-1:0] seg;
  logic signed [C-1:0] px, py;
  logic signed [C:0]   rl, rb;
  logic signed [RW-1:0] rxe, rye;
  logic [MASK_BITS-1:0] mask;
  logic [CNT_BITS-1:0]  mcnt;
  logic                 found, removed, flag, st;
  logic                 hit_now;
  eval_t                ev;

  // coordinate is the low COORD_BITS bits of a 16-bit field
  function automatic logic [C-1:0] crd(logic [15:0] f);
    return C'(f);
  endfunction

  assign s_tready = (state == IDLE) && !rst;
  assign in_seg = {crd(s_tdata[66:51]), crd(s_tdata[50:35]), crd(s_tdata[34:19]),
                   crd(s_tdata[18:3])};
  assign hit_now = (op == OP_REMOVE) ? ev.eq : ev.hit;

  stpq_eval #(.COORD_BITS(C)) u_eval (
    .clk(clk), .op(op),
    .ex0(rd[C-1:0]), .ey0(rd[2*C-1:C]), .ex1(rd[3*C-1:2*C]), .ey1(rd[4*C-1:3*C]),
    .sx0(seg[C-1:0]), .sy0(seg[2*C-1:C]), .sx1(seg[3*C-1:2*C]), .sy1(seg[4*C-1:3*C]),
    .px(px), .py(py), .rl(rl), .rb(rb), .rxe(rxe), .rye(rye), .res(ev)
  );

  always_ff @(posedge clk) begin
    if (state == SCAN && idx < count) rd <= mem[idx[IW-1:0]];
    if (s_tvalid && s_tready && s_tdata[2:0] == OP_APPEND && count < CW'(MAX_SEGMENTS))
      mem[count[IW-1:0]] <= in_seg;
    else if (state == SHIFT && idx + 1'b1 < count)
      mem[idx[IW-1:0]] <= mem[IW'(idx + 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      m_tvalid <= 1'b0;
      hv1 <= 1'b0;
      hv <= 1'b0;
    end else begin
      // read at idx into rd, evaluated into ev; hidx1 and hidx carry the index alongside
      hv <= hv1;
      hidx <= hidx1;
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            op <= s_tdata[2:0];
            seg <= in_seg;
            px <= crd(s_tdata[82:67]);
            py <= crd(s_tdata[98:83]);
            rl <= (C+1)'($signed(crd(s_tdata[114:99])));
            rb <= (C+1)'($signed(crd(s_tdata[130:115])));
            rxe <= RW'($signed(crd(s_tdata[114:99]))) + RW'(s_tdata[146:131]);
            rye <= RW'($signed(crd(s_tdata[130:115]))) + RW'(s_tdata[162:147]);
            mask <= '0; mcnt <= '0; found <= 1'b0; removed <= 1'b0;
            idx <= '0;
            flag <= 1'b0; st <= 1'b0;
            unique case (s_tdata[2:0])
              OP_APPEND: begin
                if (count < CW'(MAX_SEGMENTS)) begin
                  count <= count + 1'b1;
                  flag <= 1'b1;
                end else st <= 1'b1;
                state <= DONE;
              end
              OP_REMOVE, OP_CONTAINS, OP_POINT, OP_REGION: state <= SCAN;
              default: state <= DONE;
            endcase
          end
        end
        SCAN: begin
          if (idx < count) idx <= idx + 1'b1;
          hv1 <= (idx < count);
          hidx1 <= idx;
          state <= (idx < count) ? SCAN : TAIL;
        end
        TAIL: begin
          if (!hv && !hv1) begin
            if (op == OP_REMOVE && removed) begin
              idx <= ridx;
              state <= SHIFT;
            end else begin
              flag <= (op == OP_REMOVE) ? !found : (mcnt != '0);
              if (op == OP_REMOVE) begin mask <= '0; mcnt <= '0; end
              state <= DONE;
            end
          end
        end
        SHIFT: begin
          if (idx + 1'b1 < count) idx <= idx + 1'b1;
          else begin
            count <= count - 1'b1;
            flag <= !found;
            mask <= '0; mcnt <= '0;
            state <= DONE;
          end
        end
        DONE: begin
          if (!m_tvalid) m_tvalid <= 1'b1;
          else if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if ((state == SCAN || state == TAIL) && hv && hit_now) begin
        if (op == OP_REMOVE) begin
          if (!removed) begin
            removed <= 1'b1;
            ridx <= hidx;
          end else found <= 1'b1;
        end else begin
          if (32'(hidx) < MASK_BITS) mask <= mask | (MASK_BITS'(1) << hidx);
          if (mcnt != '1) mcnt <= mcnt + 1'b1;
        end
      end
    end
  end

  assign m_tdata = {1'b0, st, flag, mcnt, mask};
endmodule

@@ sv/stpq_checker.sv @@
// port-level checker for the segment table, bound to the top level
`include "segment_table_point_query_macros.svh"
module stpq_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [167:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [23:0]  m_tdata
);
  `STPQ_ASSERT(a_no_accept_while_out, m_tvalid |-> !s_tready)
  `STPQ_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `STPQ_ASSERT(a_flag_count, m_tvalid && m_tdata[20:16] != 5'd0 |-> m_tdata[21])
  `STPQ_ASSERT(a_status_excl, m_tvalid && m_tdata[22] |-> m_tdata[15:0] == 16'd0 && !m_tdata[21])
  `STPQ_ASSERT_RST(a_reset_idle, rst |=> !m_tvalid)
endmodule

bind segment_table_point_query stpq_checker u_stpq_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ test/tb_segment_table_point_query.sv @@
// self-checking testbench for the segment table point query block
`timescale 1ns / 1ps

module tb_segment_table_point_query;
  import stpq_pkg::*;

  typedef struct {
    logic signed [15:0] x0, y0, x1, y1;
  } seg_s;

  typedef struct packed {
    logic        status;
    logic        flag;
    logic [4:0]  count;
    logic [15:0] mask;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;

  segment_table_point_query u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the table
  seg_s table_shadow[$];
  logic [IN_BITS-1:0] pending_items[$];
  answer_t answers_due[$];
  int errors = 0;
  bit calm = 1'b0;
  bit hold_send = 1'b0;
  bit stim_done = 1'b0;

  function automatic void queue_item(logic [IN_BITS-1:0] d);
    pending_items = {pending_items, d};
  endfunction

  function automatic logic [15:0] r16();
    return 16'($urandom);
  endfunction

  function automatic seg_s seg_of(logic [IN_BITS-1:0] d);
    seg_s s;
    s.x0 = d[18:3];
    s.y0 = d[34:19];
    s.x1 = d[50:35];
    s.y1 = d[66:51];
    return s;
  endfunction

  function automatic bit same_seg(seg_s a, seg_s b);
    return a.x0 == b.x0 && a.y0 == b.y0 && a.x1 == b.x1 && a.y1 == b.y1;
  endfunction

  function automatic bit point_on(seg_s e, longint px, longint py);
    longint dx, dy, cx, cy;
    dx = longint'(e.x1) - e.x0;
    dy = longint'(e.y1) - e.y0;
    cx = px - e.x0;
    cy = py - e.y0;
    if (cy * dx - cx * dy != 0) return 1'b0;
    if (cx * dx + cy * dy < 0) return 1'b0;
    return cx * dx + cy * dy <= dx * dx + dy * dy;
  endfunction

  function automatic bit corner_in(longint x, longint y, longint l, longint b,
                                   longint xe, longint ye);
    return x >= l && x <= xe && y >= b && y <= ye;
  endfunction

  // applies one accepted item to the shadow table and returns the answer
  function automatic answer_t table_answer(logic [IN_BITS-1:0] d);
    answer_t a;
    seg_s s, e;
    logic [2:0] op;
    longint px, py, l, b, xe, ye;
    bit hit;
    a = '0;
    op = d[2:0];
    s = seg_of(d);
    px = $signed(d[82:67]);
    py = $signed(d[98:83]);
    l = $signed(d[114:99]);
    b = $signed(d[130:115]);
    xe = l + longint'(d[146:131]);
    ye = b + longint'(d[162:147]);
    case (op)
      OP_APPEND: begin
        if (table_shadow.size() >= 16) a.status = 1'b1;
        else begin
          table_shadow = {table_shadow, s};
          a.flag = 1'b1;
        end
      end
      OP_REMOVE: begin
        foreach (table_shadow[i]) begin
          if (same_seg(table_shadow[i], s)) begin
            table_shadow.delete(i);
            break;
          end
        end
        a.flag = 1'b1;
        foreach (table_shadow[i]) if (same_seg(table_shadow[i], s)) a.flag = 1'b0;
      end
      OP_CONTAINS, OP_POINT, OP_REGION: begin
        foreach (table_shadow[i]) begin
          e = table_shadow[i];
          if (op == OP_CONTAINS) hit = same_seg(e, s);
          else if (op == OP_POINT) hit = point_on(e, px, py);
          else hit = corner_in(e.x0, e.y0, l, b, xe, ye) || corner_in(e.x1, e.y1, l, b, xe, ye);
          if (hit) begin
            a.mask[i] = 1'b1;
            a.count = a.count + 5'd1;
          end
        end
        a.flag = a.count != 0;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [IN_BITS-1:0] make_item(logic [2:0] op, seg_s s,
      logic [15:0] px, logic [15:0] py, logic [15:0] l, logic [15:0] b,
      logic [15:0] w, logic [15:0] h);
    return {5'd0, h, w, b, l, py, px, s.y1, s.x1, s.y0, s.x0, op};
  endfunction

  function automatic seg_s rand_seg(int span);
    seg_s s;
    s.x0 = 16'($urandom_range(2 * span) - span);
    s.y0 = 16'($urandom_range(2 * span) - span);
    s.x1 = 16'($urandom_range(2 * span) - span);
    s.y1 = 16'($urandom_range(2 * span) - span);
    if ($urandom_range(9) == 0) s = '{r16(), r16(), r16(), r16()};
    return s;
  endfunction

  // builds a random item biased toward hits on segments appended so far
  function automatic logic [IN_BITS-1:0] rand_item(ref seg_s known[$]);
    seg_s s, k;
    int r, t;
    logic [15:0] px, py, l, b;
    r = $urandom_range(99);
    s = rand_seg(20);
    px = 16'($urandom_range(40) - 20);
    py = 16'($urandom_range(40) - 20);
    l = 16'($urandom_range(40) - 20);
    b = 16'($urandom_range(40) - 20);
    if (known.size() > 0) begin
      k = known[$urandom_range(known.size() - 1)];
      t = $urandom_range(4);
      if (r >= 20 && r < 55) s = k;
      if (r >= 55 && r < 80 && $urandom_range(1)) begin
        px = 16'(k.x0 + t * (k.x1 - k.x0) / 4);
        py = 16'(k.y0 + t * (k.y1 - k.y0) / 4);
      end
    end
    if ($urandom_range(19) == 0) begin
      px = r16(); py = r16(); l = r16(); b = r16();
    end
    if (r < 20) begin
      known = {known, s};
      return make_item(OP_APPEND, s, r16(), r16(), r16(), r16(), r16(), r16());
    end
    if (r < 35) return make_item(OP_REMOVE, s, r16(), r16(), r16(), r16(), r16(), r16());
    if (r < 50) return make_item(OP_CONTAINS, s, px, py, l, b, r16(), r16());
    if (r < 75) return make_item(OP_POINT, rand_seg(32767), px, py, l, b, r16(), r16());
    if (r < 97) return make_item(OP_REGION, rand_seg(32767), px, py, l, b,
                                 16'($urandom_range(30)), 16'($urandom_range(30)));
    return make_item(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), s, r16(), r16(),
                     r16(), r16(), r16(), r16());
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) answers_due = {answers_due, table_answer(s_tdata)};
      if (pending_items.size() > 0 && !hold_send && (calm || $urandom_range(99) >= 26)) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_items.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[22:0];
        if (answers_due.size() == 0) begin
          $error("result transfer with nothing expected: %h", m_tdata);
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (got.mask != want.mask) begin
            $error("match_mask expected %h actual %h", want.mask, got.mask);
            errors++;
          end
          if (got.count != want.count) begin
            $error("match_count expected %0d actual %0d", want.count, got.count);
            errors++;
          end
          if (got.flag != want.flag) begin
            $error("result_flag expected %0d actual %0d", want.flag, got.flag);
            errors++;
          end
          if (got.status != want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
          end
        end
      end
      m_tready <= calm || $urandom_range(99) >= 26;
    end
  end

  initial begin
    seg_s known[$];
    seg_s a, pt, deg;
    a = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};
    pt = '{-16'sd3, 16'sd4, 16'sd3, -16'sd4};
    deg = '{16'sd5, 16'sd5, 16'sd5, 16'sd5};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, reversed segment, degenerate, missing remove, full table
    queue_item(make_item(OP_APPEND, a, '0, '0, '0, '0, '0, '0));
    queue_item(make_item(OP_APPEND, pt, '0, '0, '0, '0, '0, '0));
    queue_item(make_item(OP_APPEND, deg, '0, '0, '0, '0, '0, '0));
    queue_item(make_item(OP_CONTAINS, '{a.x1, a.y1, a.x0, a.y0}, '0, '0, '0, '0, '0, '0));
    queue_item(make_item(OP_CONTAINS, a, '0, '0, '0, '0, '0, '0));
    queue_item(make_item(OP_POINT, a, '0, '0, '0, '0, '0, '0));
    queue_item(make_item(OP_POINT, a, 16'h7fff, 16'h7fff, '0, '0, '0, '0));
    queue_item(make_item(OP_POINT, a, 16'h8000, 16'h7fff, '0, '0, '0, '0));
    queue_item(make_item(OP_POINT, a, 16'd5, 16'd5, '0, '0, '0, '0));
    queue_item(make_item(OP_POINT, a, 16'd6, 16'd6, '0, '0, '0, '0));
    queue_item(make_item(OP_REGION, a, '0, '0, 16'h8000, 16'h8000, 16'hffff, 16'hffff));
    queue_item(make_item(OP_REGION, a, '0, '0, 16'h7fff, 16'h7fff, '0, '0));
    queue_item(make_item(OP_REGION, a, '0, '0, 16'd5, 16'd5, '0, '0));
    queue_item(make_item(OP_SPARE_LAST, '{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 16'hffff,
                         16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    queue_item(make_item(OP_REMOVE, deg, '0, '0, '0, '0, '0, '0));
    queue_item(make_item(OP_REMOVE, deg, '0, '0, '0, '0, '0, '0));
    repeat (15) queue_item(make_item(OP_APPEND, pt, '0, '0, '0, '0, '0, '0));
    queue_item(make_item(OP_CONTAINS, pt, '0, '0, '0, '0, '0, '0));
    queue_item(make_item(OP_REMOVE, a, '0, '0, '0, '0, '0, '0));
    queue_item(make_item(OP_POINT, pt, '0, '0, '0, '0, '0, '0));
    repeat (16) queue_item(make_item(OP_REMOVE, pt, '0, '0, '0, '0, '0, '0));
    wait (pending_items.size() == 0 && !s_tvalid && answers_due.size() == 0);
    // random part, with a calm stretch and a pause until the block drains
    for (int n = 0; n < 520; n++) begin
      if (n == 200 || n == 280) begin
        wait (pending_items.size() == 0);
        calm = (n == 200);
      end
      queue_item(rand_item(known));
      if (n == 350) begin
        wait (pending_items.size() == 0);
        hold_send = 1'b1;
        wait (!s_tvalid && answers_due.size() == 0);
        hold_send = 1'b0;
      end
    end
    wait (pending_items.size() == 0 && !s_tvalid && answers_due.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
